// File: rtl/text_console_writer_assert.svh
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// condition on this edge implies a consequence on the same edge
`define TCW_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition on this edge implies a consequence on the next edge
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// types and constants of the text console writer
`default_nettype none

package tcw_pkg;

	localparam logic [2:0] CMD_PUT    = 3'd0;
	localparam logic [2:0] CMD_SETCUR = 3'd1;
	localparam logic [2:0] CMD_DRAW   = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_BLANK     = 8'h00;

	localparam logic [15:0] HIDDEN_OFFSET = 16'hFFFF;
	localparam logic [7:0]  RESET_ATTR    = 8'h07;

	localparam logic REG_TEXT_COLOR = 1'b0;
	localparam logic REG_CURSOR_VIS = 1'b1;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] ch;
	} cell_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] byte_value;
		logic [7:0] target_row;
		logic [7:0] target_col;
		logic [7:0] cell_color;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_char;
		logic        rejected;
		logic [7:0]  cursor_row_out;
		logic [7:0]  cursor_col_out;
		logic [15:0] cursor_offset;
	} out_item_t;

	typedef enum logic [1:0] {
		SCR_WRITE,
		SCR_READ,
		SCR_SCROLL,
		SCR_FILL
	} scr_op_t;

	typedef struct packed {
		logic    start;
		scr_op_t op;
		cell_t   entry;
	} scr_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] rchar;
	} scr_stat_t;

endpackage

`default_nettype wire

// File: rtl/text_console_writer.sv
// text console writer top level: command decode, cursor and screen control
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | tcw_pkg::in_item_t
//   rsp     | out       | rsp_valid/rsp_ready  | tcw_pkg::out_item_t
//   cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// one item at a time; read cell waits for a screen memory read, put byte for a scroll
// of the whole screen where needed (at most two per byte), clear screen for a fill
// of every cell; scroll and clear walk the whole screen memory
// after reset the screen memory is filled before req_ready rises
// a waiting result sits in the output register while the next item is accepted
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  tcw_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output tcw_pkg::out_item_t rsp,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire [7:0]          cfg_data
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);

	typedef enum logic [2:0] {
		T_INIT,
		T_IDLE,
		T_EXEC,
		T_PUT,
		T_WAIT,
		T_FIN
	} t_state_t;

	t_state_t       state_q;
	t_state_t       ret_q;
	in_item_t       item_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [7:0]     color_q;
	logic           vis_q;
	logic [7:0]     rchar_q;
	logic           rej_q;
	logic           rsp_valid_q;
	out_item_t      rsp_q;

	scr_req_t       scr_req;
	scr_stat_t      scr_stat;
	logic [AW-1:0]  scr_addr;
	logic [7:0]     sel_r;
	logic [7:0]     sel_c;

	logic           on_screen;
	logic           deferred;
	logic           need_scroll;
	logic           put_now;
	logic [RW-1:0]  nx_r;
	logic [CW-1:0]  nx_c;
	logic [RW-1:0]  wr_r;
	logic [CW-1:0]  wr_c;
	logic           do_wr;
	cell_t          wcell;
	cell_t          blank;
	logic [15:0]    offset;

	assign on_screen   = (item_q.target_row < 8'(ROWS)) && (item_q.target_col < 8'(COLUMNS));
	assign deferred    = (row_q == RW'(ROWS));
	assign need_scroll = (item_q.cmd == CMD_PUT) && deferred && ((col_q != '0) || vis_q);
	assign put_now     = (state_q == T_PUT)
		|| (state_q == T_EXEC && item_q.cmd == CMD_PUT && !deferred);
	assign blank       = '{attr: color_q, ch: CH_BLANK};

	// put byte with the cursor on screen
	always_comb begin
		nx_r  = row_q;
		nx_c  = col_q;
		wr_r  = row_q;
		wr_c  = col_q;
		do_wr = 1'b0;
		wcell = blank;
		case (item_q.byte_value)
			CH_NEWLINE: begin
				nx_r = row_q + RW'(1);
				nx_c = '0;
			end
			CH_RETURN: begin
				nx_c = '0;
			end
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					nx_c = col_q - CW'(1);
				end else if (row_q != '0) begin
					nx_c = CW'(COLUMNS - 1);
					nx_r = row_q - RW'(1);
				end
				wr_r  = nx_r;
				wr_c  = nx_c;
				do_wr = 1'b1;
			end
			default: begin
				do_wr = 1'b1;
				wcell = '{attr: color_q, ch: item_q.byte_value};
				if (col_q < CW'(COLUMNS - 1)) begin
					nx_c = col_q + CW'(1);
				end else begin
					nx_c = '0;
					nx_r = row_q + RW'(1);
				end
			end
		endcase
	end

	always_comb begin
		scr_req = '{start: 1'b0, op: SCR_WRITE, entry: blank};
		sel_r   = item_q.target_row;
		sel_c   = item_q.target_col;
		if (put_now) begin
			scr_req.start = do_wr;
			scr_req.entry = wcell;
			sel_r         = 8'(wr_r);
			sel_c         = 8'(wr_c);
		end else begin
			case (state_q)
				T_INIT: begin
					scr_req = '{start: 1'b1, op: SCR_FILL,
						entry: '{attr: RESET_ATTR, ch: CH_BLANK}};
				end
				T_EXEC: begin
					case (item_q.cmd)
						CMD_PUT: begin
							scr_req.start = 1'b1;
							scr_req.op    = SCR_SCROLL;
						end
						CMD_DRAW: begin
							scr_req.start = on_screen;
							scr_req.entry = '{attr: item_q.cell_color, ch: item_q.byte_value};
						end
						CMD_READ: begin
							scr_req.start = on_screen;
							scr_req.op    = SCR_READ;
						end
						CMD_CLEAR: begin
							scr_req.start = 1'b1;
							scr_req.op    = SCR_FILL;
						end
						default: begin
						end
					endcase
				end
				T_FIN: begin
					scr_req.start = need_scroll;
					scr_req.op    = SCR_SCROLL;
				end
				default: begin
				end
			endcase
		end
	end

	assign scr_addr = AW'(sel_r * COLUMNS + sel_c);
	assign offset   = vis_q ? 16'(row_q * COLUMNS + col_q) : HIDDEN_OFFSET;

	tcw_screen #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_screen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scr_req),
		.addr   (scr_addr),
		.stat   (scr_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_ATTR;
			vis_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEXT_COLOR: color_q <= cfg_data;
				REG_CURSOR_VIS: vis_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_INIT;
			ret_q       <= T_IDLE;
			item_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			rchar_q     <= '0;
			rej_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				T_INIT: begin
					ret_q   <= T_IDLE;
					state_q <= T_WAIT;
				end
				T_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						rchar_q <= '0;
						rej_q   <= 1'b0;
						state_q <= T_EXEC;
					end
				end
				T_EXEC: begin
					case (item_q.cmd)
						CMD_PUT: begin
							if (deferred) begin
								// pending scroll from a hidden cursor goes first
								row_q   <= row_q - RW'(1);
								ret_q   <= T_PUT;
								state_q <= T_WAIT;
							end else begin
								row_q   <= nx_r;
								col_q   <= nx_c;
								state_q <= T_FIN;
							end
						end
						CMD_SETCUR: begin
							if (on_screen) begin
								row_q <= item_q.target_row[RW-1:0];
								col_q <= item_q.target_col[CW-1:0];
							end else begin
								rej_q <= 1'b1;
							end
							state_q <= T_FIN;
						end
						CMD_DRAW: begin
							rej_q   <= !on_screen;
							state_q <= T_FIN;
						end
						CMD_READ: begin
							rej_q   <= !on_screen;
							ret_q   <= T_FIN;
							state_q <= on_screen ? T_WAIT : T_FIN;
						end
						CMD_CLEAR: begin
							row_q   <= '0;
							col_q   <= '0;
							ret_q   <= T_FIN;
							state_q <= T_WAIT;
						end
						default: begin
							state_q <= T_FIN;
						end
					endcase
				end
				T_PUT: begin
					row_q   <= nx_r;
					col_q   <= nx_c;
					state_q <= T_FIN;
				end
				T_WAIT: begin
					if (scr_stat.done) begin
						if (item_q.cmd == CMD_READ) begin
							rchar_q <= scr_stat.rchar;
						end
						state_q <= ret_q;
					end
				end
				T_FIN: begin
					if (need_scroll) begin
						row_q   <= row_q - RW'(1);
						ret_q   <= T_FIN;
						state_q <= T_WAIT;
					end else if (!rsp_valid_q || rsp_ready) begin
						rsp_q.read_char      <= rchar_q;
						rsp_q.rejected       <= rej_q;
						rsp_q.cursor_row_out <= 8'(row_q);
						rsp_q.cursor_col_out <= 8'(col_q);
						rsp_q.cursor_offset  <= offset;
						rsp_valid_q          <= 1'b1;
						state_q              <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == T_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/tcw_screen.sv
// screen store with single access, scroll copy and fill sweep engine
`default_nettype none

module tcw_screen #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire               clk,
	input  wire               arst_n,
	input  tcw_pkg::scr_req_t req,
	input  wire [$clog2(ROWS*COLUMNS)-1:0] addr,
	output tcw_pkg::scr_stat_t stat
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_SWEEP,
		SC_DRAIN
	} sc_state_t;

	sc_state_t      state_q;
	logic [AW-1:0]  rd_q;
	logic           scroll_q;
	cell_t          fill_q;
	logic           done_q;
	logic           v_s1;
	logic [AW-1:0]  wr_s1;
	logic           copy_s1;

	cell_t          mem [CELLS];
	cell_t          rdata_q;

	logic           we;
	logic [AW-1:0]  waddr;
	cell_t          wdata;
	logic           re;
	logic [AW-1:0]  raddr;
	logic           rd_copy;

	// source row lies one screen row below the destination
	assign rd_copy = scroll_q && (rd_q < AW'(CELLS - COLUMNS));

	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wdata = req.entry;
		re    = 1'b0;
		raddr = addr;
		if (v_s1) begin
			we    = 1'b1;
			waddr = wr_s1;
			wdata = copy_s1 ? rdata_q : fill_q;
		end else if (state_q == SC_IDLE && req.start && req.op == SCR_WRITE) begin
			we = 1'b1;
		end
		if (state_q == SC_SWEEP) begin
			re    = rd_copy;
			raddr = rd_q + AW'(COLUMNS);
		end else if (state_q == SC_IDLE && req.start && req.op == SCR_READ) begin
			re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SC_IDLE;
			rd_q     <= '0;
			scroll_q <= 1'b0;
			fill_q   <= '0;
			done_q   <= 1'b0;
			v_s1     <= 1'b0;
			wr_s1    <= '0;
			copy_s1  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						case (req.op)
							SCR_READ: begin
								done_q <= 1'b1;
							end
							SCR_SCROLL, SCR_FILL: begin
								scroll_q <= (req.op == SCR_SCROLL);
								fill_q   <= req.entry;
								rd_q     <= '0;
								state_q  <= SC_SWEEP;
							end
							default: begin
							end
						endcase
					end
				end
				SC_SWEEP: begin
					v_s1    <= 1'b1;
					wr_s1   <= rd_q;
					copy_s1 <= rd_copy;
					rd_q    <= rd_q + AW'(1);
					if (rd_q == AW'(CELLS - 1)) begin
						state_q <= SC_DRAIN;
					end
				end
				SC_DRAIN: begin
					done_q  <= 1'b1;
					state_q <= SC_IDLE;
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign stat.done  = done_q;
	assign stat.rchar = rdata_q.ch;

endmodule

`default_nettype wire

// File: rtl/tcw_checker.sv
// port checker for the text console writer and its bind
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire                clk,
	input wire                arst_n,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input tcw_pkg::out_item_t rsp
);
	import tcw_pkg::*;

	`TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result item dropped or changed while stalled")
	`TCW_ASSERT_IMPL(a_rej_no_char, rsp_valid && rsp.rejected, rsp.read_char == 8'h00, "rejected item returned a character")
	`TCW_ASSERT_IMPL(a_col_range, rsp_valid, rsp.cursor_col_out < 8'(COLUMNS), "cursor column off screen")
	`TCW_ASSERT_IMPL(a_row_range, rsp_valid, rsp.cursor_row_out <= 8'(ROWS), "cursor row beyond deferred row")
	`TCW_ASSERT_IMPL(a_offset, rsp_valid && rsp.cursor_offset != HIDDEN_OFFSET, rsp.cursor_offset == 16'(rsp.cursor_row_out * COLUMNS + rsp.cursor_col_out), "cursor offset does not match row and column")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// File: bench/text_console_writer_check.sv
// checker of the text console writer: tracks screen and cursor, compares every result
`timescale 1ns / 1ps

module text_console_writer_check #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	input  wire                req_ready,
	input  tcw_pkg::in_item_t  req,
	input  wire                rsp_valid,
	input  wire                rsp_ready,
	input  tcw_pkg::out_item_t rsp,
	input  wire                cfg_we,
	input  wire                cfg_index,
	input  wire [7:0]          cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 compared,
	output int                 scrolls,
	output int                 late_scrolls
);
	import tcw_pkg::*;

	localparam int CELLS        = ROWS * COLUMNS;
	localparam int SHOWN_ERRORS = 10;

	cell_t      screen [CELLS];
	int         row_now;
	int         col_now;
	logic [7:0] text_attr;
	logic       cursor_on;
	out_item_t  status_q [$];

	task automatic write_cell(input int r, input int c, input logic [7:0] ch,
			input logic [7:0] attr);
		if (r < ROWS && c < COLUMNS) begin
			screen[r * COLUMNS + c] = {attr, ch};
		end
	endtask

	task automatic shift_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {text_attr, CH_BLANK};
		if (row_now > 0) row_now--;
		scrolls++;
	endtask

	task automatic print_byte(input logic [7:0] ch);
		// a scroll held back by a hidden cursor is done before anything else
		if (row_now >= ROWS) begin
			shift_screen();
			late_scrolls++;
		end
		case (ch)
			CH_NEWLINE: begin
				row_now++;
				col_now = 0;
			end
			CH_RETURN: col_now = 0;
			CH_BACKSPACE: begin
				if (col_now > 0) begin
					col_now--;
				end else if (row_now > 0) begin
					col_now = COLUMNS - 1;
					row_now--;
				end
				write_cell(row_now, col_now, CH_BLANK, text_attr);
			end
			default: begin
				write_cell(row_now, col_now, ch, text_attr);
				if (col_now < COLUMNS - 1) begin
					col_now++;
				end else begin
					col_now = 0;
					row_now++;
				end
			end
		endcase
		// landing exactly on column 0 below the screen waits while the cursor is hidden
		if (row_now >= ROWS && (col_now > 0 || cursor_on)) shift_screen();
	endtask

	task automatic run_command(input in_item_t it, output out_item_t res);
		logic in_range;
		res = '0;
		in_range = it.target_row < ROWS && it.target_col < COLUMNS;
		case (it.cmd)
			CMD_PUT: print_byte(it.byte_value);
			CMD_SETCUR, CMD_DRAW, CMD_READ: begin
				if (!in_range) begin
					res.rejected = 1'b1;
				end else if (it.cmd == CMD_SETCUR) begin
					row_now = int'(it.target_row);
					col_now = int'(it.target_col);
				end else if (it.cmd == CMD_DRAW) begin
					write_cell(int'(it.target_row), int'(it.target_col), it.byte_value,
						it.cell_color);
				end else begin
					res.read_char = screen[it.target_row * COLUMNS + it.target_col].ch;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, CH_BLANK};
				row_now = 0;
				col_now = 0;
			end
			default: ;
		endcase
		res.cursor_row_out = row_now[7:0];
		res.cursor_col_out = col_now[7:0];
		res.cursor_offset  = cursor_on ? 16'(row_now * COLUMNS + col_now) : HIDDEN_OFFSET;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CH_BLANK};
			row_now      = 0;
			col_now      = 0;
			text_attr    = RESET_ATTR;
			cursor_on    = 1'b0;
			status_q.delete();
			errors       = 0;
			pending      = 0;
			compared     = 0;
			scrolls      = 0;
			late_scrolls = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TEXT_COLOR) text_attr = cfg_data;
				else cursor_on = cfg_data[0];
			end
			// results leave after their item is taken, so check before predicting
			if (rsp_valid && rsp_ready) begin
				if (status_q.size() == 0) begin
					errors++;
					if (errors <= SHOWN_ERRORS)
						$display("unexpected result: char %h rej %b row %0d col %0d off %h",
							rsp.read_char, rsp.rejected, rsp.cursor_row_out,
							rsp.cursor_col_out, rsp.cursor_offset);
				end else begin
					want = status_q.pop_front();
					compared++;
					if (rsp.read_char !== want.read_char || rsp.rejected !== want.rejected ||
							rsp.cursor_row_out !== want.cursor_row_out ||
							rsp.cursor_col_out !== want.cursor_col_out ||
							rsp.cursor_offset !== want.cursor_offset) begin
						errors++;
						if (errors <= SHOWN_ERRORS) begin
							$display("result %0d: expected char %h rej %b row %0d col %0d off %h",
								compared, want.read_char, want.rejected, want.cursor_row_out,
								want.cursor_col_out, want.cursor_offset);
							$display("result %0d: got      char %h rej %b row %0d col %0d off %h",
								compared, rsp.read_char, rsp.rejected, rsp.cursor_row_out,
								rsp.cursor_col_out, rsp.cursor_offset);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				run_command(req, want);
				status_q.push_back(want);
			end
			pending = status_q.size();
		end
	end

endmodule

// File: bench/text_console_writer_test.sv
// top of the text console writer testbench: command stimulus, result stalls and verdict
`timescale 1ns / 1ps

module text_console_writer_test;
	import tcw_pkg::*;

	localparam int COLUMNS        = 80;
	localparam int ROWS           = 25;
	localparam int MAX_GAP        = 17;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 80;
	localparam int SQUEEZE_PHASE  = 4;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 20;
	localparam int QUIET_LIMIT    = 25000;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_item_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_item_t rsp;
	logic      cfg_we;
	logic      cfg_index;
	logic [7:0] cfg_data;

	int   errors;
	int   pending;
	int   compared;
	int   scrolls;
	int   late_scrolls;
	int   sent = 0;
	int   quiet = 0;
	bit   req_calm = 1'b0;
	bit   rsp_calm = 1'b0;
	bit   squeeze_on = 1'b0;
	logic rsp_taken = 1'b0;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	text_console_writer_check #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) console_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.compared    (compared),
		.scrolls     (scrolls),
		.late_scrolls(late_scrolls)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_taken <= rsp_valid && rsp_ready;
	end

	// a put byte with two scrolls can keep the block busy for two screen walks
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("no item moved for %0d cycles", quiet);
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// result side: random hold before each item, one long hold-off on request
	initial begin
		int hold;
		bit squeezed;
		hold = 0;
		squeezed = 1'b0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_on && !squeezed) begin
				rsp_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
				squeezed = 1'b1;
				hold = 0;
			end else if (rsp_taken) begin
				hold = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input in_item_t it);
		int gap;
		gap = req_calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until the block has handed back every item it took
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic in_item_t cmd_item(input logic [2:0] cmd, input logic [7:0] ch,
			input logic [7:0] r, input logic [7:0] c, input logic [7:0] attr);
		in_item_t it;
		it.cmd        = cmd;
		it.byte_value = ch;
		it.target_row = r;
		it.target_col = c;
		it.cell_color = attr;
		return it;
	endfunction

	function automatic in_item_t random_command();
		in_item_t it;
		int pick;
		it.cmd        = CMD_PUT;
		it.byte_value = 8'($urandom_range(0, 255));
		it.target_row = 8'($urandom_range(0, ROWS - 1));
		it.target_col = 8'($urandom_range(0, COLUMNS - 1));
		it.cell_color = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			case ($urandom_range(0, 9))
				0: it.byte_value = CH_NEWLINE;
				1: it.byte_value = CH_RETURN;
				2, 3: it.byte_value = CH_BACKSPACE;
				default: ;
			endcase
		end else if (pick < 52) begin
			// park the cursor near the last cells so the next prints scroll
			it.cmd        = CMD_SETCUR;
			it.target_row = 8'(ROWS - 1 - $urandom_range(0, 1));
			it.target_col = 8'(COLUMNS - 1 - $urandom_range(0, 3));
		end else if (pick < 60) begin
			it.cmd = CMD_SETCUR;
		end else if (pick < 70) begin
			it.cmd = CMD_DRAW;
		end else if (pick < 80) begin
			it.cmd = CMD_READ;
		end else if (pick < 91) begin
			// coordinates over the whole byte range, mostly off screen
			it.cmd        = 3'($urandom_range(CMD_SETCUR, CMD_READ));
			it.target_row = 8'($urandom_range(0, 255));
			it.target_col = 8'($urandom_range(0, 255));
		end else if (pick < 94) begin
			it.cmd = CMD_CLEAR;
		end else begin
			it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		end
		return it;
	endfunction

	initial begin
		logic [7:0] color;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_TEXT_COLOR;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the screen store is initialized before the block takes anything
		while (!req_ready) @(negedge clk);

		write_reg(REG_TEXT_COLOR, 8'hFF);
		write_reg(REG_CURSOR_VIS, 8'h00);
		send_item(cmd_item(CMD_READ, 8'h00, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_DRAW, 8'hFF, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'hFF));
		send_item(cmd_item(CMD_READ, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
		send_item(cmd_item(CMD_SETCUR, 8'h00, 8'(ROWS), 8'd0, 8'h00));
		send_item(cmd_item(CMD_DRAW, 8'h00, 8'd0, 8'(COLUMNS), 8'h00));
		send_item(cmd_item(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// backspace at the top left corner stays put
		send_item(cmd_item(CMD_PUT, CH_BACKSPACE, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_PUT, 8'h41, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_PUT, CH_RETURN, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_PUT, 8'h00, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_PUT, CH_BACKSPACE, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_SETCUR, 8'h00, 8'd1, 8'd0, 8'h00));
		send_item(cmd_item(CMD_PUT, CH_BACKSPACE, 8'd0, 8'd0, 8'h00));
		// hidden cursor wrapping off the last cell holds the scroll back
		send_item(cmd_item(CMD_SETCUR, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
		send_item(cmd_item(CMD_PUT, 8'h5A, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_READ, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
		send_item(cmd_item(CMD_PUT, CH_NEWLINE, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_SPARE_LO, 8'h00, 8'd0, 8'd0, 8'h00));
		settle();

		// showing the cursor while a scroll is held back must not scroll
		write_reg(REG_CURSOR_VIS, 8'h01);
		send_item(cmd_item(CMD_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(cmd_item(CMD_PUT, CH_NEWLINE, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_SETCUR, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
		send_item(cmd_item(CMD_PUT, 8'h7F, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_CLEAR, 8'h00, 8'd0, 8'd0, 8'h00));
		send_item(cmd_item(CMD_READ, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 8'h00));
		settle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: color = 8'h00;
				1: color = 8'hFF;
				default: color = 8'($urandom_range(0, 255));
			endcase
			write_reg(REG_TEXT_COLOR, color);
			write_reg(REG_CURSOR_VIS, 8'(ph[0]));
			req_calm   = (ph == 2);
			rsp_calm   = (ph == 3);
			squeeze_on = (ph == SQUEEZE_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_command());
			settle();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d commands, %0d results compared", sent, compared);
		$display("screen scrolled %0d times, %0d of them held back by a hidden cursor",
			scrolls, late_scrolls);
		if (errors == 0 && pending == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
